FILE: rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_LIST       = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_LIST_START,
        OP_LIST_NEXT
    } t_op;

    // controller -> datapath
    typedef struct packed {
        t_op     op;
        logic    load;      // load the result register
        t_status status;
        logic    use_rd;    // result value from read data, else zero
        logic    last;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;    // the entry being listed is the back entry
        logic out_free;     // result register can take a new item
    } t_dp_sts;

endpackage

FILE: rtl/deq_if.sv
// Request and response channel interfaces of the double-ended queue.
`timescale 1ns / 1ps

interface deq_req_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  req_type;
    logic signed [31:0] push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface deq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_value;
    logic        [1:0]  status;
    logic               last;

    modport source (output valid, output out_value, output status, output last, input ready);
    modport sink   (input valid, input out_value, input status, input last, output ready);
endinterface

FILE: rtl/deq_ctrl.sv
// Request sequencer of the double-ended queue.
`timescale 1ns / 1ps

module deq_ctrl import deq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_req_type,
    input  t_dp_sts    i_sts,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_LIST
    } t_state;

    t_state r_state;
    t_state n_state;
    t_req   w_req;

    assign w_req = t_req'(i_req_type);

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '{op: OP_NONE, load: 1'b0, status: ST_OK, use_rd: 1'b0, last: 1'b1};
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    case (w_req)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            o_cmd.load = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.op = (w_req == REQ_PUSH_FRONT) ? OP_PUSH_FRONT
                                                                     : OP_PUSH_BACK;
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            if (i_sts.empty) begin
                                o_cmd.load   = 1'b1;
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.op = (w_req == REQ_POP_FRONT) ? OP_POP_FRONT
                                                                    : OP_POP_BACK;
                                n_state  = S_POP;
                            end
                        end
                        REQ_LIST: begin
                            if (i_sts.empty) begin
                                o_cmd.load   = 1'b1;
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.op = OP_LIST_START;
                                n_state  = S_LIST;
                            end
                        end
                        default: begin
                            // unused codes are swallowed without a result
                        end
                    endcase
                end
            end
            S_POP: begin
                if (i_sts.out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.use_rd = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_sts.out_free) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.use_rd = 1'b1;
                    o_cmd.last   = i_sts.list_last;
                    if (i_sts.list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.op = OP_LIST_NEXT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_sts.out_free)
        else $error("result loaded while the result register is occupied");

    a_list_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> !i_sts.empty)
        else $error("listing an empty queue");

endmodule

FILE: rtl/deq_dp.sv
// Ring buffer storage, pointers and result register of the double-ended queue.
`timescale 1ns / 1ps

module deq_dp import deq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic signed [31:0] i_push_value,
    input  logic               i_out_ready,
    output t_dp_sts            o_sts,
    output logic               o_out_valid,
    output logic signed [31:0] o_out_value,
    output logic        [1:0]  o_out_status,
    output logic               o_out_last
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [PW-1:0] LAST_POS = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic signed [31:0] r_mem [DEPTH];

    logic [PW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [PW-1:0] r_list_pos, n_list_pos;
    logic [PW-1:0] r_idx, n_idx;
    logic signed [31:0] r_rd_data;

    logic          w_we, w_re;
    logic [PW-1:0] w_waddr, w_raddr;
    logic [PW-1:0] w_prev_front, w_back_pos, w_tail_pos;

    function automatic logic [PW-1:0] wrap_sum(input logic [SW-1:0] s);
        return (s >= SW'(DEPTH)) ? PW'(s - SW'(DEPTH)) : PW'(s);
    endfunction

    function automatic logic [PW-1:0] step_pos(input logic [PW-1:0] p);
        return (p == LAST_POS) ? '0 : p + PW'(1);
    endfunction

    assign w_prev_front = (r_front == '0) ? LAST_POS : r_front - PW'(1);
    assign w_back_pos   = wrap_sum(SW'(r_front) + SW'(r_count));
    assign w_tail_pos   = wrap_sum(SW'(r_front) + SW'(r_count) - SW'(1));

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.full      = (r_count == FULL_CNT);
    assign o_sts.list_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_sts.out_free  = !o_out_valid || i_out_ready;

    always_comb begin
        w_we       = 1'b0;
        w_re       = 1'b0;
        w_waddr    = w_back_pos;
        w_raddr    = r_front;
        n_front    = r_front;
        n_count    = r_count;
        n_list_pos = r_list_pos;
        n_idx      = r_idx;
        case (i_cmd.op)
            OP_PUSH_FRONT: begin
                w_we    = 1'b1;
                w_waddr = w_prev_front;
                n_front = w_prev_front;
                n_count = r_count + CW'(1);
            end
            OP_PUSH_BACK: begin
                w_we    = 1'b1;
                n_count = r_count + CW'(1);
            end
            OP_POP_FRONT: begin
                w_re    = 1'b1;
                n_front = step_pos(r_front);
                n_count = r_count - CW'(1);
            end
            OP_POP_BACK: begin
                w_re    = 1'b1;
                w_raddr = w_tail_pos;
                n_count = r_count - CW'(1);
            end
            OP_LIST_START: begin
                w_re       = 1'b1;
                n_list_pos = step_pos(r_front);
                n_idx      = '0;
            end
            OP_LIST_NEXT: begin
                w_re       = 1'b1;
                w_raddr    = r_list_pos;
                n_list_pos = step_pos(r_list_pos);
                n_idx      = r_idx + PW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= i_push_value;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            if (i_cmd.load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_list_pos <= n_list_pos;
        r_idx      <= n_idx;
        if (i_cmd.load) begin
            o_out_value  <= i_cmd.use_rd ? r_rd_data : 32'sd0;
            o_out_status <= i_cmd.status;
            o_out_last   <= i_cmd.last;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_PUSH_FRONT || i_cmd.op == OP_PUSH_BACK)
            |-> !o_sts.full ##1 (r_count == $past(r_count) + CW'(1)))
        else $error("push did not add exactly one entry");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_POP_FRONT || i_cmd.op == OP_POP_BACK)
            |-> !o_sts.empty ##1 (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not remove exactly one entry");

endmodule

FILE: rtl/double_ended_queue.sv
// Bounded double-ended queue: push/pop at either end, or list front to back.
// A push loads the result register as the request is taken; a pop reads its slot into
// the registered read data, then loads the result register; a listing does so per entry.
// Pushes go one per cycle while the result register is free; reads use the single
// registered read port, and a pop or listing takes no new request until it is done.
// Reset (synchronous, active low) empties the queue; slot contents are not cleared.
`timescale 1ns / 1ps

module double_ended_queue import deq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    deq_req_if.sink   i_req,
    deq_rsp_if.source o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_sts      (w_sts),
        .o_in_ready (i_req.ready),
        .o_cmd      (w_cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_push_value (i_req.push_value),
        .i_out_ready  (o_rsp.ready),
        .o_sts        (w_sts),
        .o_out_valid  (o_rsp.valid),
        .o_out_value  (o_rsp.out_value),
        .o_out_status (o_rsp.status),
        .o_out_last   (o_rsp.last)
    );

endmodule
